/* rtl/assert_macros.svh */
// Assertion macros used by the checker module of the glyph coverage filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on clk, disabled while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

/* rtl/sgcf_pkg.sv */
// Types, constants and the coverage curve of the glyph coverage filter.
`default_nettype none

package sgcf_pkg;

	localparam int ROW_W = 24;
	localparam int COL_W = 3;
	localparam int COV_W = 8;
	localparam int WIN_W = 7;

	localparam int MEAN_SUM_W = 10;
	localparam logic [9:0] DIV3_MUL = 10'd683;
	localparam int DIV3_SHIFT = 11;

	typedef logic [COV_W-1:0] cov_t;
	typedef logic [3:0] wsum_t;

	typedef enum logic [1:0] {
		MODE_GRAY  = 2'd0,
		MODE_RGB   = 2'd1,
		MODE_BGR   = 2'd2,
		MODE_SHARP = 2'd3
	} mode_t;

	function automatic cov_t coverage_curve(input wsum_t sum);
		cov_t cov;
		case (sum)
			4'd0: cov = 8'd0;
			4'd1: cov = 8'd40;
			4'd2: cov = 8'd85;
			4'd3: cov = 8'd125;
			4'd4: cov = 8'd160;
			4'd5: cov = 8'd190;
			4'd6: cov = 8'd214;
			4'd7: cov = 8'd234;
			4'd8: cov = 8'd247;
			default: cov = 8'd255;
		endcase
		return cov;
	endfunction

endpackage

`default_nettype wire

/* rtl/subpixel_glyph_coverage_filter.sv */
// Subpixel glyph coverage filter: 1-2-3-2-1 window per subsample, curve lookup, mode routing.
//
// Usage:
//   Input channel (in_valid, in_stall, glyph_row, pixel_column) takes one glyph row and
//   a pixel column per transaction. Output channel (out_valid, out_stall, red_coverage,
//   green_coverage, blue_coverage) returns one coverage triple per input transaction.
//   Configuration channel (cfg_valid, cfg_ready, smoothing_mode) writes the mode
//   register; cfg_ready is always high. Write it only while the block is empty.
// Timing:
//   Two register stages: input register, then result register. The result register loads
//   from the input register, so each result passes through both registers before it can
//   be taken. Throughput is one transaction per cycle while out_stall is low, set by the
//   single filter pass between the two stages.
// Reset:
//   arst_n low empties both stages and sets the mode to gray.
// Stall:
//   A stalled result holds in the result register; the input register keeps filling
//   behind it, and in_stall rises only when both stages are full and out_stall is high.
`default_nettype none

module subpixel_glyph_coverage_filter #(
	parameter int GLYPH_WIDTH = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [sgcf_pkg::ROW_W-1:0]    glyph_row,
	input  wire logic [sgcf_pkg::COL_W-1:0]    pixel_column,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [sgcf_pkg::COV_W-1:0]    red_coverage,
	output      logic [sgcf_pkg::COV_W-1:0]    green_coverage,
	output      logic [sgcf_pkg::COV_W-1:0]    blue_coverage,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [1:0]                    smoothing_mode
);

	localparam int SUB = GLYPH_WIDTH * 3;
	localparam int EXT_W = (SUB + 4 > 28) ? SUB + 4 : 28;
	localparam int IDX_W = $clog2(EXT_W);

	function automatic sgcf_pkg::wsum_t window_sum(input logic [4:0] w);
		return 4'({3'b0, w[0]} + {2'b0, w[1], 1'b0} + {2'b0, w[2], w[2]}
			+ {2'b0, w[3], 1'b0} + {3'b0, w[4]});
	endfunction

	sgcf_pkg::mode_t mode_q;

	logic                         valid_s1;
	logic [sgcf_pkg::ROW_W-1:0]   row_s1;
	logic [sgcf_pkg::COL_W-1:0]   col_s1;

	logic                         valid_s2;
	sgcf_pkg::cov_t               red_s2;
	sgcf_pkg::cov_t               green_s2;
	sgcf_pkg::cov_t               blue_s2;

	logic adv_s1;
	logic adv_s2;

	logic [EXT_W-1:0]                ext;
	logic [4:0]                      base;
	logic [sgcf_pkg::WIN_W-1:0]      win;
	sgcf_pkg::cov_t                  cov_a;
	sgcf_pkg::cov_t                  cov_c;
	sgcf_pkg::cov_t                  cov_d;
	logic [sgcf_pkg::MEAN_SUM_W-1:0] cov_sum;
	logic [19:0]                     mean_prod;
	sgcf_pkg::cov_t                  mean;
	sgcf_pkg::cov_t                  red_d;
	sgcf_pkg::cov_t                  green_d;
	sgcf_pkg::cov_t                  blue_d;

	assign cfg_ready = 1'b1;
	assign adv_s2 = !valid_s2 || !out_stall;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	assign out_valid = valid_s2;
	assign red_coverage = red_s2;
	assign green_coverage = green_s2;
	assign blue_coverage = blue_s2;

	// ext[j] holds subsample position j-2; positions outside the row read zero
	always_comb begin
		ext = '0;
		for (int j = 2; j < SUB + 2; j++) begin
			if (SUB + 1 - j < sgcf_pkg::ROW_W) begin
				ext[j] = row_s1[SUB + 1 - j];
			end
		end
	end

	assign base = 5'({2'b0, col_s1} * 5'd3);
	assign win = ext[IDX_W'(base) +: sgcf_pkg::WIN_W];

	assign cov_a = sgcf_pkg::coverage_curve(window_sum(win[4:0]));
	assign cov_c = sgcf_pkg::coverage_curve(window_sum(win[5:1]));
	assign cov_d = sgcf_pkg::coverage_curve(window_sum(win[6:2]));

	// divide by three through the reciprocal; exact for sums up to 765
	assign cov_sum = {2'b0, cov_a} + {2'b0, cov_c} + {2'b0, cov_d};
	assign mean_prod = {10'b0, cov_sum} * {10'b0, sgcf_pkg::DIV3_MUL};
	assign mean = mean_prod[sgcf_pkg::DIV3_SHIFT +: sgcf_pkg::COV_W];

	always_comb begin
		unique case (mode_q)
			sgcf_pkg::MODE_RGB: begin
				red_d = cov_a;
				green_d = cov_c;
				blue_d = cov_d;
			end
			sgcf_pkg::MODE_BGR: begin
				red_d = cov_d;
				green_d = cov_c;
				blue_d = cov_a;
			end
			default: begin
				red_d = mean;
				green_d = mean;
				blue_d = mean;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sgcf_pkg::MODE_GRAY;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= sgcf_pkg::mode_t'(smoothing_mode);
			end
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			row_s1 <= glyph_row;
			col_s1 <= pixel_column;
		end
		if (adv_s2 && valid_s1) begin
			red_s2 <= red_d;
			green_s2 <= green_d;
			blue_s2 <= blue_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/sgcf_checker.sv */
// Port-level assertion checker for the glyph coverage filter, with its bind.
`default_nettype none

`include "assert_macros.svh"

module sgcf_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [sgcf_pkg::COV_W-1:0] red_coverage,
	input wire logic [sgcf_pkg::COV_W-1:0] green_coverage,
	input wire logic [sgcf_pkg::COV_W-1:0] blue_coverage,
	input wire logic                       cfg_valid,
	input wire logic                       cfg_ready,
	input wire logic [1:0]                 smoothing_mode
);

	sgcf_pkg::mode_t                mode_q;
	logic                           gray_mode;
	logic                           in_acc;
	logic                           out_held;
	logic                           gray_split;
	logic [3*sgcf_pkg::COV_W-1:0]   cov_all;

	// track the mode register from the configuration transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sgcf_pkg::MODE_GRAY;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= sgcf_pkg::mode_t'(smoothing_mode);
		end
	end

	assign gray_mode = (mode_q == sgcf_pkg::MODE_GRAY) || (mode_q == sgcf_pkg::MODE_SHARP);
	assign in_acc = in_valid && !in_stall;
	assign out_held = out_valid && out_stall;
	assign cov_all = {red_coverage, green_coverage, blue_coverage};
	assign gray_split = (red_coverage != green_coverage) || (green_coverage != blue_coverage);

	`ASSERT_CLK(a_out_hold, out_held |=> out_valid && $stable(cov_all), "stalled result changed")
	`ASSERT_CLK(a_in_stall_full, in_stall |-> out_held, "input stalled while output free")
	`ASSERT_CLK(a_latency, in_acc ##1 !out_stall |=> out_valid, "transaction did not reach output")
	`ASSERT_NEVER(a_gray_equal, out_valid && gray_mode && gray_split, "gray channels differ")

endmodule

bind subpixel_glyph_coverage_filter sgcf_checker u_sgcf_checker (.*);

`default_nettype wire
